>>> design/gpsr_pkg.sv
// Shared types, command codes and reply tables of the game pad serial responder.
package gpsr_pkg;

    // Reply buffer geometry
    localparam int REPLY_DEPTH = 22;
    localparam int BUF_AW      = $clog2(REPLY_DEPTH);
    localparam int IDX_W       = 5;

    // Item kinds carried on the input tuser
    localparam logic [1:0] FUNC_START  = 2'd0;
    localparam logic [1:0] FUNC_BYTE   = 2'd1;
    localparam logic [1:0] FUNC_BUTTON = 2'd2;
    localparam logic [1:0] FUNC_AXIS   = 2'd3;

    // Pad modes
    localparam logic [1:0] MODE_DIGITAL = 2'd0;
    localparam logic [1:0] MODE_ANALOG  = 2'd1;
    localparam logic [1:0] MODE_NATIVE  = 2'd2;

    // Host command bytes
    localparam logic [7:0] CMD_VREF   = 8'h40;
    localparam logic [7:0] CMD_MASKQ  = 8'h41;
    localparam logic [7:0] CMD_POLL   = 8'h42;
    localparam logic [7:0] CMD_CONFIG = 8'h43;
    localparam logic [7:0] CMD_MODE   = 8'h44;
    localparam logic [7:0] CMD_MODEL  = 8'h45;
    localparam logic [7:0] CMD_ACT    = 8'h46;
    localparam logic [7:0] CMD_COMB   = 8'h47;
    localparam logic [7:0] CMD_MODEQ  = 8'h4C;
    localparam logic [7:0] CMD_RUMBLE = 8'h4D;
    localparam logic [7:0] CMD_NATIVE = 8'h4F;

    // Fixed reply bytes
    localparam logic [7:0] RPL_IDLE   = 8'hFF;
    localparam logic [7:0] RPL_CONFIG = 8'hF3;
    localparam logic [7:0] RPL_HEADER = 8'h5A;

    // Reply lengths
    localparam logic [IDX_W-1:0] LEN_SHORT  = IDX_W'(5);
    localparam logic [IDX_W-1:0] LEN_TABLE  = IDX_W'(9);
    localparam logic [IDX_W-1:0] LEN_NATIVE = IDX_W'(21);

    typedef logic [7:0] t_tab7 [7];

    localparam t_tab7 TAB_VREF   = '{8'h5A, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h5A};
    localparam t_tab7 TAB_ZERO   = '{8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    localparam t_tab7 TAB_MODEL  = '{8'h5A, 8'h03, 8'h02, 8'h00, 8'h02, 8'h01, 8'h00};
    localparam t_tab7 TAB_ACT0   = '{8'h5A, 8'h00, 8'h00, 8'h01, 8'h02, 8'h00, 8'h0A};
    localparam t_tab7 TAB_ACT1   = '{8'h5A, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h14};
    localparam t_tab7 TAB_COMB   = '{8'h5A, 8'h00, 8'h00, 8'h02, 8'h00, 8'h01, 8'h00};
    localparam t_tab7 TAB_NATIVE = '{8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A};

    localparam logic [7:0] MODE_REPLY [4] = '{8'h41, 8'h73, 8'h79, 8'h79};

    // Button positions reported in the pressure bytes, in reply order
    localparam logic [3:0] PRESS_ORDER [12] = '{4'd5, 4'd7, 4'd4, 4'd6, 4'd12, 4'd13,
                                                4'd14, 4'd15, 4'd10, 4'd11, 4'd8, 4'd9};

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic [3:0] button_index;
        logic       button_pressed;
        logic       stick_select;
        logic       axis_select;
    } t_item;

    typedef struct packed {
        logic [7:0] reply_byte;
        logic       overrun;
        logic       bad_command;
    } t_result;

endpackage

>>> design/gpsr_engine.sv
// Pad state and command engine: updates the state and forms the reply for one item.
module gpsr_engine
    import gpsr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    logic [7:0]       r_buf [REPLY_DEPTH];
    logic [7:0]       n_buf [REPLY_DEPTH];
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_len, n_len;
    logic [7:0]       r_cmd, n_cmd;
    logic             r_in_config, n_in_config;
    logic [1:0]       r_mode, n_mode;
    logic             r_locked, n_locked;
    logic [7:0]       r_mask [2];
    logic [7:0]       n_mask [2];
    logic [15:0]      r_buttons, n_buttons;
    logic [7:0]       r_axes [4];
    logic [7:0]       n_axes [4];
    logic [7:0]       r_rumble [8];
    logic [7:0]       n_rumble [8];

    logic [IDX_W-1:0] w_idx_inc;
    logic [7:0]       w_v;
    t_tab7            w_tab;
    logic             w_load;
    logic             w_poll;
    logic             w_read;
    logic             w_rumble_rst;

    assign w_v       = i_item.data_byte;
    assign w_idx_inc = r_idx + IDX_W'(1);

    always_comb begin
        n_buf        = r_buf;
        n_idx        = r_idx;
        n_len        = r_len;
        n_cmd        = r_cmd;
        n_in_config  = r_in_config;
        n_mode       = r_mode;
        n_locked     = r_locked;
        n_mask       = r_mask;
        n_buttons    = r_buttons;
        n_axes       = r_axes;
        n_rumble     = r_rumble;
        w_tab        = TAB_ZERO;
        w_load       = 1'b0;
        w_poll       = 1'b0;
        w_read       = 1'b0;
        w_rumble_rst = 1'b0;
        o_result     = '0;

        case (i_item.func)
            FUNC_BUTTON: begin
                n_buttons[i_item.button_index] = ~i_item.button_pressed;
            end
            FUNC_AXIS: begin
                n_axes[{i_item.stick_select, i_item.axis_select}] = w_v;
            end
            FUNC_START: begin
                n_idx               = '0;
                n_len               = LEN_SHORT;
                o_result.reply_byte = RPL_IDLE;
            end
            default: begin
                if (r_idx > r_len) begin
                    o_result.overrun = 1'b1;
                end else if (r_idx == '0) begin
                    n_idx = IDX_W'(1);
                    if (!r_in_config && w_v != CMD_POLL && w_v != CMD_CONFIG) begin
                        // Outside config only poll and config commands are answered; the rest overrun.
                        n_len               = '0;
                        o_result.reply_byte = RPL_CONFIG;
                    end else begin
                        n_cmd               = w_v;
                        o_result.reply_byte = RPL_CONFIG;
                        case (w_v)
                            CMD_CONFIG: begin
                                if (r_in_config) begin
                                    w_load = 1'b1;
                                end else begin
                                    w_poll              = 1'b1;
                                    o_result.reply_byte = MODE_REPLY[r_mode];
                                end
                            end
                            CMD_POLL: begin
                                w_poll              = 1'b1;
                                o_result.reply_byte = MODE_REPLY[r_mode];
                            end
                            CMD_VREF: begin
                                w_tab  = TAB_VREF;
                                w_load = 1'b1;
                            end
                            CMD_MASKQ: begin
                                w_load = 1'b1;
                                if (r_mode != MODE_DIGITAL) begin
                                    w_tab[1] = r_mask[0];
                                    w_tab[2] = r_mask[1];
                                    w_tab[3] = 8'h03;
                                    w_tab[6] = RPL_HEADER;
                                end
                            end
                            CMD_MODE: begin
                                w_load       = 1'b1;
                                w_rumble_rst = 1'b1;
                            end
                            CMD_MODEL: begin
                                w_tab    = TAB_MODEL;
                                w_tab[3] = {7'd0, r_mode != MODE_DIGITAL};
                                w_load   = 1'b1;
                            end
                            CMD_ACT: begin
                                w_tab  = TAB_ACT0;
                                w_load = 1'b1;
                            end
                            CMD_COMB: begin
                                w_tab  = TAB_COMB;
                                w_load = 1'b1;
                            end
                            CMD_MODEQ: begin
                                w_load = 1'b1;
                            end
                            CMD_RUMBLE: begin
                                // Hand back the old rumble bytes, then restore defaults.
                                for (int k = 0; k < 7; k++) begin
                                    w_tab[k] = r_rumble[k];
                                end
                                w_load       = 1'b1;
                                w_rumble_rst = 1'b1;
                            end
                            CMD_NATIVE: begin
                                w_tab  = TAB_NATIVE;
                                w_load = 1'b1;
                            end
                            default: begin
                                n_len                = '0;
                                o_result.bad_command = 1'b1;
                                o_result.reply_byte  = RPL_IDLE;
                            end
                        endcase
                    end
                end else begin
                    n_idx  = w_idx_inc;
                    w_read = 1'b1;
                    case (r_cmd)
                        CMD_CONFIG: begin
                            if (w_idx_inc == IDX_W'(3)) begin
                                n_in_config = (w_v != 8'd0);
                            end
                        end
                        CMD_MODE: begin
                            if (w_idx_inc == IDX_W'(3)) begin
                                if (w_v < 8'd2 && !r_locked) begin
                                    n_mode = w_v[0] ? MODE_ANALOG : MODE_DIGITAL;
                                end
                            end else if (w_idx_inc == IDX_W'(4)) begin
                                n_locked = (w_v == 8'd3);
                            end
                        end
                        CMD_ACT: begin
                            if (w_idx_inc == IDX_W'(3) && w_v < 8'd2) begin
                                w_tab  = w_v[0] ? TAB_ACT1 : TAB_ACT0;
                                w_load = 1'b1;
                            end
                        end
                        CMD_MODEQ: begin
                            if (w_idx_inc == IDX_W'(3) && w_v < 8'd2) begin
                                n_buf[6] = w_v[0] ? 8'd7 : 8'd4;
                            end
                        end
                        CMD_RUMBLE: begin
                            if (w_idx_inc >= IDX_W'(3) && w_idx_inc <= IDX_W'(9)) begin
                                n_rumble[3'(w_idx_inc - IDX_W'(2))] = w_v;
                            end
                        end
                        CMD_NATIVE: begin
                            if (w_idx_inc == IDX_W'(3)) begin
                                n_mask[0] = w_v;
                            end else if (w_idx_inc == IDX_W'(4)) begin
                                n_mask[1] = w_v;
                            end else if (w_idx_inc == IDX_W'(5)) begin
                                if (!w_v[0]) begin
                                    n_mode = MODE_DIGITAL;
                                end else if (!w_v[1]) begin
                                    n_mode = MODE_ANALOG;
                                end else begin
                                    n_mode = MODE_NATIVE;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        endcase

        if (w_load) begin
            for (int k = 0; k < 7; k++) begin
                n_buf[2 + k] = w_tab[k];
            end
            n_len = LEN_TABLE;
        end

        if (w_rumble_rst) begin
            n_rumble[0] = RPL_HEADER;
            for (int k = 1; k < 8; k++) begin
                n_rumble[k] = 8'hFF;
            end
        end

        if (w_poll) begin
            n_buf[2] = RPL_HEADER;
            n_buf[3] = r_buttons[7:0];
            n_buf[4] = r_buttons[15:8];
            n_len    = LEN_SHORT;
            if (r_mode != MODE_DIGITAL) begin
                n_len = LEN_TABLE;
                for (int k = 0; k < 4; k++) begin
                    n_buf[5 + k] = r_axes[k];
                end
                if (r_mode != MODE_ANALOG && !r_in_config) begin
                    // A pressed button reads full pressure, a released one zero.
                    for (int k = 0; k < 12; k++) begin
                        n_buf[9 + k] = {8{~r_buttons[PRESS_ORDER[k]]}};
                    end
                    n_len = LEN_NATIVE;
                end
            end
        end

        if (w_read) begin
            if ({1'b0, w_idx_inc} < (IDX_W + 1)'(REPLY_DEPTH)) begin
                o_result.reply_byte = n_buf[w_idx_inc[BUF_AW-1:0]];
            end else begin
                o_result.overrun    = 1'b1;
                o_result.reply_byte = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_buf <= n_buf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_len       <= '0;
            r_cmd       <= '0;
            r_in_config <= 1'b0;
            r_mode      <= MODE_DIGITAL;
            r_locked    <= 1'b0;
            r_mask      <= '{8'hFF, 8'hFF};
            r_buttons   <= 16'hFFFF;
            r_axes      <= '{8'h80, 8'h80, 8'h80, 8'h80};
            r_rumble    <= '{8'h5A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        end else if (i_fire) begin
            r_idx       <= n_idx;
            r_len       <= n_len;
            r_cmd       <= n_cmd;
            r_in_config <= n_in_config;
            r_mode      <= n_mode;
            r_locked    <= n_locked;
            r_mask      <= n_mask;
            r_buttons   <= n_buttons;
            r_axes      <= n_axes;
            r_rumble    <= n_rumble;
        end
    end

endmodule

>>> design/game_pad_serial_responder_top.sv
// Top level of the game pad serial responder: stream handshakes around the command engine.
//
// The block answers a host's byte-exchange serial link on behalf of a game pad.
// Input channel (s_axis): tuser carries the item kind (start of transfer, host byte,
// button event, stick axis update); tdata carries the host byte or axis value, the
// button position and press flag, and the stick and axis selectors.
// Output channel (m_axis): one item for every start or host byte, none for button
// and stick events. tdata is the reply byte; tuser flags overrun (reply beyond the
// current reply length, data zero) and bad command (unknown command in config, 0xFF).
// An item accepted at a clock edge is held in the input register, processed once the
// result register can take its reply, and the reply is then offered from that register.
// One item is taken every cycle while the receiver keeps up; the engine's update of
// the pad state and reply buffer is a single combinational pass between the input
// register and the result register.
// When the receiver stalls, the reply waits in the result register and the item
// behind it waits in the input register; tready drops only once both are full.
// Synchronous reset (active low) empties both registers and restores the pad
// state: digital mode, unlocked, all buttons released, sticks centred.
module game_pad_serial_responder_top
    import gpsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] data_byte, [11:8] button_index, [12] button_pressed,
    // [13] stick_select, [14] axis_select, [15] zero
    input  logic [15:0] i_s_axis_tdata,
    // [1:0] func
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] reply_byte
    output logic [7:0]  o_m_axis_tdata,
    // [0] overrun, [1] bad_command
    output logic [1:0]  o_m_axis_tuser
);

    logic    r_in_valid, n_in_valid;
    t_item   r_in_item;
    logic    r_out_valid, n_out_valid;
    t_result r_out;
    t_result w_result;
    logic    w_out_free;
    logic    w_fire;
    logic    w_accept;
    logic    w_has_result;

    // The engine runs when the result register can take whatever it produces.
    assign w_out_free   = !r_out_valid || i_m_axis_tready;
    assign w_fire       = r_in_valid && w_out_free;
    assign w_has_result = w_fire &&
                          (r_in_item.func == FUNC_START || r_in_item.func == FUNC_BYTE);

    assign o_s_axis_tready = !r_in_valid || w_fire;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign n_in_valid  = w_accept || (r_in_valid && !w_fire);
    assign n_out_valid = w_has_result || (r_out_valid && !i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item.func           <= i_s_axis_tuser;
            r_in_item.data_byte      <= i_s_axis_tdata[7:0];
            r_in_item.button_index   <= i_s_axis_tdata[11:8];
            r_in_item.button_pressed <= i_s_axis_tdata[12];
            r_in_item.stick_select   <= i_s_axis_tdata[13];
            r_in_item.axis_select    <= i_s_axis_tdata[14];
        end
        if (w_has_result) begin
            r_out <= w_result;
        end
    end

    gpsr_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.reply_byte;
    assign o_m_axis_tuser  = {r_out.bad_command, r_out.overrun};

endmodule

>>> design/gpsr_checker.sv
// Port-level checks of the game pad serial responder, bound to its top level.
module gpsr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    // A reply that is not taken stays offered unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled reply changed");

    // Overrun and bad command are never raised together.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("both flags set");

    // An overrun reply carries zero.
    a_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == 8'h00)
        else $error("overrun reply not zero");

    // A bad command reply carries all ones.
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tdata == 8'hFF)
        else $error("bad command reply not 0xFF");

    // The input side is never blocked while the output side is empty.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked with empty output");

endmodule

bind game_pad_serial_responder_top gpsr_checker u_gpsr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
